FILE: src/segisect_pkg.sv
package segisect_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_BITS   = 32;

  // deltas, cross-product terms, cross products, |c3|+|c4|
  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int CW  = PW + 1;
  localparam int SW  = CW + 1;
  // |delta| magnitude, |delta|*d1, shifted numerator, quotient
  localparam int MW  = COORD_BITS;
  localparam int NPW = MW + CW;
  localparam int NW  = NPW + FRAC_BITS;
  localparam int QW  = COORD_BITS + FRAC_BITS;
  // fixed-point result before clamping
  localparam int PTW = COORD_BITS + FRAC_BITS + 2;
  localparam int EW  = (PTW > OUT_BITS + 1) ? PTW : OUT_BITS + 1;

  localparam int FRONT_STAGES = 5;
  localparam int LATENCY      = FRONT_STAGES + QW + 1;

  typedef struct packed {
    logic                          hit;
    logic                          degen;
    logic                          neg_x;
    logic                          neg_y;
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  start_y;
  } side_t;

  typedef struct packed {
    logic             valid;
    side_t            side;
    logic [SW-1:0]    den;
    logic [NPW-1:0]   num_x;
    logic [NPW-1:0]   num_y;
  } front_t;

  typedef struct packed {
    logic           valid;
    side_t          side;
    logic [QW-1:0]  quot_x;
    logic [QW-1:0]  quot_y;
    logic           rnz_x;
    logic           rnz_y;
  } div_t;

endpackage

FILE: src/segisect_front.sv
module segisect_front
  import segisect_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [COORD_BITS-1:0]  a_start_x_i,
  input  logic signed [COORD_BITS-1:0]  a_start_y_i,
  input  logic signed [COORD_BITS-1:0]  a_end_x_i,
  input  logic signed [COORD_BITS-1:0]  a_end_y_i,
  input  logic signed [COORD_BITS-1:0]  b_start_x_i,
  input  logic signed [COORD_BITS-1:0]  b_start_y_i,
  input  logic signed [COORD_BITS-1:0]  b_end_x_i,
  input  logic signed [COORD_BITS-1:0]  b_end_y_i,
  output front_t                        front_o
);

  logic [FRONT_STAGES-1:0] vld_q, vld_d;

  // stage 1: differences
  logic signed [DW-1:0] ax_q, ay_q, bx_q, by_q;
  logic signed [DW-1:0] e1x_q, e1y_q, e2x_q, e2y_q, f1x_q, f1y_q, f2x_q, f2y_q;
  logic signed [COORD_BITS-1:0] sx1_q, sy1_q;
  // stage 2: products
  logic signed [PW-1:0] p1a_q, p1b_q, p2a_q, p2b_q, p3a_q, p3b_q, p4a_q, p4b_q;
  logic signed [DW-1:0] ax2_q, ay2_q;
  logic signed [COORD_BITS-1:0] sx2_q, sy2_q;
  // stage 3: cross products
  logic signed [CW-1:0] c1_q, c2_q, c3_q, c4_q;
  logic signed [DW-1:0] ax3_q, ay3_q;
  logic signed [COORD_BITS-1:0] sx3_q, sy3_q;
  // stage 4: signs, magnitudes, denominator
  logic                 hit4_q, negx4_q, negy4_q;
  logic [CW-1:0]        d1_q;
  logic [SW-1:0]        den4_q;
  logic [MW-1:0]        magx_q, magy_q;
  logic signed [COORD_BITS-1:0] sx4_q, sy4_q;
  // stage 5: numerators
  logic                 hit5_q, negx5_q, negy5_q, degen5_q;
  logic [SW-1:0]        den5_q;
  logic [NPW-1:0]       numx_q, numy_q;
  logic signed [COORD_BITS-1:0] sx5_q, sy5_q;

  logic                 c1_pos, c1_neg, c2_pos, c2_neg, c3_pos, c3_neg, c4_pos, c4_neg;
  logic [CW-1:0]        d1_d, d2_d;
  logic signed [DW-1:0] nax, nay;

  assign vld_d = {vld_q[FRONT_STAGES-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_comb begin
    c1_pos = !c1_q[CW-1] && (|c1_q);
    c1_neg = c1_q[CW-1];
    c2_pos = !c2_q[CW-1] && (|c2_q);
    c2_neg = c2_q[CW-1];
    c3_pos = !c3_q[CW-1] && (|c3_q);
    c3_neg = c3_q[CW-1];
    c4_pos = !c4_q[CW-1] && (|c4_q);
    c4_neg = c4_q[CW-1];
    d1_d   = c3_neg ? CW'(-c3_q) : CW'(c3_q);
    d2_d   = c4_neg ? CW'(-c4_q) : CW'(c4_q);
    nax    = -ax3_q;
    nay    = -ay3_q;
  end

  always_ff @(posedge clk_i) begin
    ax_q  <= DW'(a_end_x_i)   - DW'(a_start_x_i);
    ay_q  <= DW'(a_end_y_i)   - DW'(a_start_y_i);
    bx_q  <= DW'(b_end_x_i)   - DW'(b_start_x_i);
    by_q  <= DW'(b_end_y_i)   - DW'(b_start_y_i);
    e1x_q <= DW'(b_start_x_i) - DW'(a_start_x_i);
    e1y_q <= DW'(b_start_y_i) - DW'(a_start_y_i);
    e2x_q <= DW'(b_end_x_i)   - DW'(a_start_x_i);
    e2y_q <= DW'(b_end_y_i)   - DW'(a_start_y_i);
    f1x_q <= DW'(a_start_x_i) - DW'(b_start_x_i);
    f1y_q <= DW'(a_start_y_i) - DW'(b_start_y_i);
    f2x_q <= DW'(a_end_x_i)   - DW'(b_start_x_i);
    f2y_q <= DW'(a_end_y_i)   - DW'(b_start_y_i);
    sx1_q <= a_start_x_i;
    sy1_q <= a_start_y_i;

    p1a_q <= ax_q * e1y_q;
    p1b_q <= ay_q * e1x_q;
    p2a_q <= ax_q * e2y_q;
    p2b_q <= ay_q * e2x_q;
    p3a_q <= bx_q * f1y_q;
    p3b_q <= by_q * f1x_q;
    p4a_q <= bx_q * f2y_q;
    p4b_q <= by_q * f2x_q;
    ax2_q <= ax_q;
    ay2_q <= ay_q;
    sx2_q <= sx1_q;
    sy2_q <= sy1_q;

    c1_q  <= CW'(p1a_q) - CW'(p1b_q);
    c2_q  <= CW'(p2a_q) - CW'(p2b_q);
    c3_q  <= CW'(p3a_q) - CW'(p3b_q);
    c4_q  <= CW'(p4a_q) - CW'(p4b_q);
    ax3_q <= ax2_q;
    ay3_q <= ay2_q;
    sx3_q <= sx2_q;
    sy3_q <= sy2_q;

    // touch or cross: neither pair shares a strict sign
    hit4_q  <= !((c1_pos && c2_pos) || (c1_neg && c2_neg)) &&
               !((c3_pos && c4_pos) || (c3_neg && c4_neg));
    d1_q    <= d1_d;
    den4_q  <= SW'(d1_d) + SW'(d2_d);
    negx4_q <= ax3_q[DW-1];
    negy4_q <= ay3_q[DW-1];
    magx_q  <= ax3_q[DW-1] ? nax[MW-1:0] : ax3_q[MW-1:0];
    magy_q  <= ay3_q[DW-1] ? nay[MW-1:0] : ay3_q[MW-1:0];
    sx4_q   <= sx3_q;
    sy4_q   <= sy3_q;

    numx_q   <= NPW'(magx_q) * NPW'(d1_q);
    numy_q   <= NPW'(magy_q) * NPW'(d1_q);
    den5_q   <= den4_q;
    degen5_q <= (den4_q == '0);
    hit5_q   <= hit4_q;
    negx5_q  <= negx4_q;
    negy5_q  <= negy4_q;
    sx5_q    <= sx4_q;
    sy5_q    <= sy4_q;
  end

  always_comb begin
    front_o.valid        = vld_q[FRONT_STAGES-1];
    front_o.side.hit     = hit5_q;
    front_o.side.degen   = degen5_q;
    front_o.side.neg_x   = negx5_q;
    front_o.side.neg_y   = negy5_q;
    front_o.side.start_x = sx5_q;
    front_o.side.start_y = sy5_q;
    front_o.den          = den5_q;
    front_o.num_x        = numx_q;
    front_o.num_y        = numy_q;
  end

endmodule

FILE: src/segisect_div.sv
module segisect_div
  import segisect_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  front_t front_i,
  output div_t   div_o
);

  typedef struct packed {
    logic [SW-1:0] r;
    logic [QW-1:0] w;
  } step_t;

  // one restoring step: shift in the next numerator bit, quotient bit shifts in at the bottom
  function automatic step_t div_step(input logic [SW-1:0] r, input logic [QW-1:0] w,
                                     input logic [SW-1:0] d);
    logic [SW:0] t;
    logic [SW:0] diff;
    step_t       o;
    t    = {r, w[QW-1]};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      o.r = diff[SW-1:0];
      o.w = {w[QW-2:0], 1'b1};
    end else begin
      o.r = t[SW-1:0];
      o.w = {w[QW-2:0], 1'b0};
    end
    return o;
  endfunction

  logic [NW-1:0] nx_full, ny_full;
  logic [QW-1:0] vld_q;
  side_t         side_q [QW];
  logic [SW-1:0] den_q  [QW];
  step_t         sx_q   [QW];
  step_t         sy_q   [QW];

  // quotient fits in QW bits, so the top of the numerator already lies below den
  assign nx_full = NW'(front_i.num_x) << FRAC_BITS;
  assign ny_full = NW'(front_i.num_y) << FRAC_BITS;

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic          v_prev;
    side_t         side_prev;
    logic [SW-1:0] den_prev;
    step_t         x_prev, y_prev;

    if (k == 0) begin : g_first
      assign v_prev    = front_i.valid;
      assign side_prev = front_i.side;
      assign den_prev  = front_i.den;
      assign x_prev.r  = SW'(nx_full[NW-1:QW]);
      assign x_prev.w  = nx_full[QW-1:0];
      assign y_prev.r  = SW'(ny_full[NW-1:QW]);
      assign y_prev.w  = ny_full[QW-1:0];
    end else begin : g_next
      assign v_prev    = vld_q[k-1];
      assign side_prev = side_q[k-1];
      assign den_prev  = den_q[k-1];
      assign x_prev    = sx_q[k-1];
      assign y_prev    = sy_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= v_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= side_prev;
      den_q[k]  <= den_prev;
      sx_q[k]   <= div_step(x_prev.r, x_prev.w, den_prev);
      sy_q[k]   <= div_step(y_prev.r, y_prev.w, den_prev);
    end
  end

  always_comb begin
    div_o.valid  = vld_q[QW-1];
    div_o.side   = side_q[QW-1];
    div_o.quot_x = sx_q[QW-1].w;
    div_o.quot_y = sy_q[QW-1].w;
    div_o.rnz_x  = |sx_q[QW-1].r;
    div_o.rnz_y  = |sy_q[QW-1].r;
  end

endmodule

FILE: src/segment_intersection.sv
// Channel   Direction  Handshake                     Payload
// request   in         start & !busy                 a_/b_ start/end x/y, signed 16 bit
// result    out        result_valid_o, one cycle     hit, degenerate, point_x/y Q16.16
//
// A request passes the front, the divider and the output register before its strobe;
// a new request may enter every cycle. The 32 stages are a restoring divider, one
// quotient bit per stage, and set the depth. busy stays low: nothing stalls, results
// must be taken when strobed. Reset clears only the valid bits; no payload is reset.
module segment_intersection
  import segisect_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  a_start_x_i,
  input  logic signed [COORD_BITS-1:0]  a_start_y_i,
  input  logic signed [COORD_BITS-1:0]  a_end_x_i,
  input  logic signed [COORD_BITS-1:0]  a_end_y_i,
  input  logic signed [COORD_BITS-1:0]  b_start_x_i,
  input  logic signed [COORD_BITS-1:0]  b_start_y_i,
  input  logic signed [COORD_BITS-1:0]  b_end_x_i,
  input  logic signed [COORD_BITS-1:0]  b_end_y_i,
  output logic                          result_valid_o,
  output logic                          hit_o,
  output logic                          degenerate_o,
  output logic signed [OUT_BITS-1:0]    point_x_o,
  output logic signed [OUT_BITS-1:0]    point_y_o
);

  front_t front;
  div_t   div;
  logic   valid_q;
  logic   hit_q, degen_q;
  logic signed [OUT_BITS-1:0] px_q, py_q;

  // a_start + delta*d1/den, truncated toward zero, clamped to the output range
  function automatic logic signed [OUT_BITS-1:0] fix_point(
      input logic signed [COORD_BITS-1:0] st, input logic neg, input logic [QW-1:0] q,
      input logic rnz, input logic degen);
    logic signed [PTW-1:0] base;
    logic signed [PTW-1:0] b;
    logic signed [EW-1:0]  e;
    logic signed [OUT_BITS-1:0] res;
    base = PTW'(st) <<< FRAC_BITS;
    if (degen) begin
      b = base;
    end else if (!neg) begin
      b = base + $signed(PTW'(q));
    end else begin
      b = base - $signed(PTW'(q)) - $signed(PTW'(rnz));
    end
    if (!degen && rnz && (b < 0)) begin
      b = b + PTW'(1);
    end
    e = EW'(b);
    if ((&e[EW-1:OUT_BITS-1]) || !(|e[EW-1:OUT_BITS-1])) begin
      res = e[OUT_BITS-1:0];
    end else if (e[EW-1]) begin
      res = {1'b1, {(OUT_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, {(OUT_BITS-1){1'b1}}};
    end
    return res;
  endfunction

  assign busy = 1'b0;

  segisect_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (start && !busy),
    .a_start_x_i (a_start_x_i),
    .a_start_y_i (a_start_y_i),
    .a_end_x_i   (a_end_x_i),
    .a_end_y_i   (a_end_y_i),
    .b_start_x_i (b_start_x_i),
    .b_start_y_i (b_start_y_i),
    .b_end_x_i   (b_end_x_i),
    .b_end_y_i   (b_end_y_i),
    .front_o     (front)
  );

  segisect_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .front_i (front),
    .div_o   (div)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= div.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q   <= div.side.hit;
    degen_q <= div.side.degen;
    px_q    <= fix_point(div.side.start_x, div.side.neg_x, div.quot_x, div.rnz_x,
                         div.side.degen);
    py_q    <= fix_point(div.side.start_y, div.side.neg_y, div.quot_y, div.rnz_y,
                         div.side.degen);
  end

  assign result_valid_o = valid_q;
  assign hit_o          = hit_q;
  assign degenerate_o   = degen_q;
  assign point_x_o      = px_q;
  assign point_y_o      = py_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY result_valid_o)
    else $error("request did not produce a result strobe on time");

  a_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching request");

  a_degen_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && degenerate_o) |->
      (point_x_o == (OUT_BITS'($past(a_start_x_i, LATENCY)) <<< FRAC_BITS)))
    else $error("degenerate x is not the first start point");

  a_degen_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && degenerate_o) |->
      (point_y_o == (OUT_BITS'($past(a_start_y_i, LATENCY)) <<< FRAC_BITS)))
    else $error("degenerate y is not the first start point");

endmodule

FILE: verif/segisect_checker.sv
module segisect_checker
  import segisect_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic signed [COORD_BITS-1:0]  a_start_x_i,
  input  logic signed [COORD_BITS-1:0]  a_start_y_i,
  input  logic signed [COORD_BITS-1:0]  a_end_x_i,
  input  logic signed [COORD_BITS-1:0]  a_end_y_i,
  input  logic signed [COORD_BITS-1:0]  b_start_x_i,
  input  logic signed [COORD_BITS-1:0]  b_start_y_i,
  input  logic signed [COORD_BITS-1:0]  b_end_x_i,
  input  logic signed [COORD_BITS-1:0]  b_end_y_i,
  input  logic                          result_valid_i,
  input  logic                          hit_i,
  input  logic                          degenerate_i,
  input  logic signed [OUT_BITS-1:0]    point_x_i,
  input  logic signed [OUT_BITS-1:0]    point_y_i,
  output int                            fail_cnt_o,
  output int                            pending_o,
  output int                            hit_cnt_o,
  output int                            degen_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                        hit;
    logic                        degen;
    logic signed [OUT_BITS-1:0]  px;
    logic signed [OUT_BITS-1:0]  py;
  } crossing_t;

  crossing_t crossings_q[$];

  function automatic int sgn(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic logic signed [OUT_BITS-1:0] clamp_q(logic signed [127:0] v);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = 128'sd2147483647;
    lo = -128'sd2147483648;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[OUT_BITS-1:0];
  endfunction

  // start + delta*d1/s in fixed point, truncated toward zero (s > 0)
  function automatic logic signed [OUT_BITS-1:0] lerp_fix(longint st, longint dl,
                                                         longint d1, longint s);
    logic signed [127:0] w_st;
    logic signed [127:0] w_dl;
    logic signed [127:0] w_d1;
    logic signed [127:0] w_s;
    logic signed [127:0] num;
    w_st = st;
    w_dl = dl;
    w_d1 = d1;
    w_s  = s;
    num  = (w_st * w_s + w_dl * w_d1) * (128'sd1 <<< FRAC_BITS);
    return clamp_q(num / w_s);
  endfunction

  function automatic crossing_t predict_crossing(longint a1x, longint a1y, longint a2x,
                                                 longint a2y, longint b1x, longint b1y,
                                                 longint b2x, longint b2y);
    crossing_t r;
    longint ax, ay, bx, by, c1, c2, c3, c4, d1, d2, s;
    logic signed [127:0] w;
    ax = a2x - a1x;
    ay = a2y - a1y;
    bx = b2x - b1x;
    by = b2y - b1y;
    c1 = ax * (b1y - a1y) - ay * (b1x - a1x);
    c2 = ax * (b2y - a1y) - ay * (b2x - a1x);
    c3 = bx * (a1y - b1y) - by * (a1x - b1x);
    c4 = bx * (a2y - b1y) - by * (a2x - b1x);
    r.hit = (sgn(c1) * sgn(c2) <= 0) && (sgn(c3) * sgn(c4) <= 0);
    d1 = (c3 < 0) ? -c3 : c3;
    d2 = (c4 < 0) ? -c4 : c4;
    s  = d1 + d2;
    r.degen = (s == 0);
    if (r.degen) begin
      w = a1x;
      r.px = clamp_q(w * (128'sd1 <<< FRAC_BITS));
      w = a1y;
      r.py = clamp_q(w * (128'sd1 <<< FRAC_BITS));
    end else begin
      r.px = lerp_fix(a1x, ax, d1, s);
      r.py = lerp_fix(a1y, ay, d1, s);
    end
    return r;
  endfunction

  initial begin
    fail_cnt_o  = 0;
    pending_o   = 0;
    hit_cnt_o   = 0;
    degen_cnt_o = 0;
  end

  always @(posedge clk_i) begin
    crossing_t e;
    if (rst_ni && start_i && !busy_i)
      crossings_q.push_back(predict_crossing(a_start_x_i, a_start_y_i, a_end_x_i,
                                             a_end_y_i, b_start_x_i, b_start_y_i,
                                             b_end_x_i, b_end_y_i));
    if (rst_ni && result_valid_i) begin
      if (crossings_q.size() == 0) begin
        fail_cnt_o++;
        if (fail_cnt_o <= 10) $display("%0t: result with no request outstanding", $realtime);
      end else begin
        e = crossings_q.pop_front();
        hit_cnt_o   += e.hit;
        degen_cnt_o += e.degen;
        if (hit_i !== e.hit || degenerate_i !== e.degen ||
            point_x_i !== e.px || point_y_i !== e.py) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10)
            $display("%0t: exp h=%0b d=%0b x=%0d y=%0d got h=%0b d=%0b x=%0d y=%0d",
                     $realtime, e.hit, e.degen, e.px, e.py,
                     hit_i, degenerate_i, point_x_i, point_y_i);
        end
      end
    end
    pending_o = crossings_q.size();
  end

endmodule

FILE: verif/tb.sv
module tb;
  import segisect_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef struct {
    coord_t a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y;
  } seg_pair_t;

  localparam coord_t CMAX = 16'sh7fff;
  localparam coord_t CMIN = 16'sh8000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t a_start_x = '0, a_start_y = '0, a_end_x = '0, a_end_y = '0;
  coord_t b_start_x = '0, b_start_y = '0, b_end_x = '0, b_end_y = '0;
  logic result_valid, hit, degenerate;
  logic signed [OUT_BITS-1:0] point_x, point_y;
  int fail_cnt, pending, hit_cnt, degen_cnt;
  int requests;
  int idle_pct;

  always #2 clk_i = ~clk_i;

  segment_intersection uut (
    .clk_i, .rst_ni, .start, .busy,
    .a_start_x_i(a_start_x), .a_start_y_i(a_start_y),
    .a_end_x_i(a_end_x), .a_end_y_i(a_end_y),
    .b_start_x_i(b_start_x), .b_start_y_i(b_start_y),
    .b_end_x_i(b_end_x), .b_end_y_i(b_end_y),
    .result_valid_o(result_valid), .hit_o(hit), .degenerate_o(degenerate),
    .point_x_o(point_x), .point_y_o(point_y)
  );

  segisect_checker chk (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy),
    .a_start_x_i(a_start_x), .a_start_y_i(a_start_y),
    .a_end_x_i(a_end_x), .a_end_y_i(a_end_y),
    .b_start_x_i(b_start_x), .b_start_y_i(b_start_y),
    .b_end_x_i(b_end_x), .b_end_y_i(b_end_y),
    .result_valid_i(result_valid), .hit_i(hit), .degenerate_i(degenerate),
    .point_x_i(point_x), .point_y_i(point_y),
    .fail_cnt_o(fail_cnt), .pending_o(pending),
    .hit_cnt_o(hit_cnt), .degen_cnt_o(degen_cnt)
  );

  // called at a rising edge; returns after the request is taken and any drawn idle cycles
  task automatic send_pair(seg_pair_t p);
    start     <= 1'b1;
    a_start_x <= p.a1x; a_start_y <= p.a1y; a_end_x <= p.a2x; a_end_y <= p.a2y;
    b_start_x <= p.b1x; b_start_y <= p.b1y; b_end_x <= p.b2x; b_end_y <= p.b2y;
    do @(posedge clk_i); while (busy);
    requests++;
    // idle cycles drawn one at a time, idle_pct percent each
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  function automatic seg_pair_t mk(int a1x, int a1y, int a2x, int a2y,
                                   int b1x, int b1y, int b2x, int b2y);
    seg_pair_t p;
    p.a1x = coord_t'(a1x); p.a1y = coord_t'(a1y);
    p.a2x = coord_t'(a2x); p.a2y = coord_t'(a2y);
    p.b1x = coord_t'(b1x); p.b1y = coord_t'(b1y);
    p.b2x = coord_t'(b2x); p.b2y = coord_t'(b2y);
    return p;
  endfunction

  function automatic int rnd_small(int r);
    return $urandom_range(2 * r) - r;
  endfunction

  function automatic seg_pair_t rnd_pair();
    seg_pair_t p;
    int px, py, dx, dy, r1, r2, r3, r4, r, bx, by;
    case ($urandom_range(9))
      0, 1, 2: begin  // full range
        p = mk($urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom);
      end
      3: begin  // all four points on one line
        px = rnd_small(1000); py = rnd_small(1000);
        dx = rnd_small(30);   dy = rnd_small(30);
        r1 = rnd_small(20);   r2 = rnd_small(20);
        r3 = rnd_small(20);   r4 = rnd_small(20);
        p = mk(px + r1 * dx, py + r1 * dy, px + r2 * dx, py + r2 * dy,
               px + r3 * dx, py + r3 * dy, px + r4 * dx, py + r4 * dy);
      end
      4: begin  // zero-length second segment
        bx = rnd_small(200); by = rnd_small(200);
        p = mk(rnd_small(200), rnd_small(200), rnd_small(200), rnd_small(200),
               bx, by, bx, by);
      end
      5: begin  // large coordinates near the extremes
        p = mk(32767 - $urandom_range(50), -32768 + $urandom_range(50),
               -32768 + $urandom_range(50), 32767 - $urandom_range(50),
               -32768 + $urandom_range(50), -32768 + $urandom_range(50),
               32767 - $urandom_range(50), 32767 - $urandom_range(50));
      end
      default: begin  // small window, crossings common
        r = (|$urandom_range(3)) ? 20 : 2000;
        p = mk(rnd_small(r), rnd_small(r), rnd_small(r), rnd_small(r),
               rnd_small(r), rnd_small(r), rnd_small(r), rnd_small(r));
      end
    endcase
    return p;
  endfunction

  initial begin
    seg_pair_t dir[$];
    requests = 0;
    idle_pct = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    dir.push_back(mk(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN));
    dir.push_back(mk(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX));
    dir.push_back(mk(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    dir.push_back(mk(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    dir.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1));
    dir.push_back(mk(0, 0, 10, 10, 0, 10, 10, 0));     // plain cross
    dir.push_back(mk(0, 0, 10, 0, 5, 0, 5, 7));        // T touch at endpoint
    dir.push_back(mk(0, 0, 10, 0, 10, 0, 20, 5));      // shared endpoint
    dir.push_back(mk(0, 0, 10, 0, 0, 3, 10, 3));       // parallel, apart
    dir.push_back(mk(0, 0, 10, 0, 5, 0, 20, 0));       // collinear overlap
    dir.push_back(mk(0, 0, 4, 0, 7, 0, 20, 0));        // collinear, disjoint
    dir.push_back(mk(-3, 5, 9, -7, 2, 2, 2, 2));       // zero-length B
    dir.push_back(mk(3, 3, 3, 3, 0, 0, 7, 7));         // zero-length A on B
    dir.push_back(mk(0, 0, 10, 1, 20, 5, 30, -5));     // miss, point off segment
    dir.push_back(mk(7, 3, -5, -2, 0, 4, 1, -9));      // negative deltas, remainder
    dir.push_back(mk(-7, -3, 5, 2, 1, -9, 0, 4));
    dir.push_back(mk(0, 0, 3, 0, 1, -1, 2, 2));        // third-fraction point
    dir.push_back(mk(CMIN, 0, CMAX, 0, 0, CMIN, 1, CMAX));
    dir.push_back(mk(0, CMIN, 0, CMAX, CMIN, 1, CMAX, 0));
    dir.push_back(mk(16'sh5555, 16'sh2aaa, 16'sh2aaa, 16'sh5555,
                     16'sh2aaa, 16'sh2aaa, 16'sh5555, 16'sh5555));
    foreach (dir[i]) send_pair(dir[i]);
    start <= 1'b0;

    // let the pipe drain completely before the random part
    while (pending != 0) @(posedge clk_i);
    @(posedge clk_i);

    idle_pct = 14;
    repeat (500) send_pair(rnd_pair());
    idle_pct = 49;
    repeat (500) send_pair(rnd_pair());
    idle_pct = 0;
    repeat (500) send_pair(rnd_pair());
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("%0d segment pairs checked: %0d touching or crossing, %0d degenerate",
             requests, hit_cnt, degen_cnt);
    $display("covered extremes, collinear, zero-length and random pairs under idle gaps");
    if (fail_cnt == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
src/segisect_pkg.sv
src/segisect_front.sv
src/segisect_div.sv
src/segment_intersection.sv
verif/segisect_checker.sv
verif/tb.sv
